### src/pid_trapezoid_antiwindup_unit_defines.svh
// assertion macros for the pid trapezoid anti-windup unit
`ifndef PID_TRAPEZOID_ANTIWINDUP_UNIT_DEFINES_SVH
`define PID_TRAPEZOID_ANTIWINDUP_UNIT_DEFINES_SVH

// implication checked in the same cycle
`define PTA_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// implication checked in the next cycle
`define PTA_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

### src/pta_pkg.sv
// shared types and constants of the pid trapezoid anti-windup unit
package pta_pkg;

    typedef struct packed {
        logic               func;
        logic signed [31:0] process_value;
        logic signed [31:0] set_point;
        logic        [31:0] delta_time;
        logic signed [31:0] integral_scale;
    } pta_in_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic        [1:0]  integral_clamped;
        logic               output_clipped;
    } pta_out_t;

    localparam logic [2:0] CFG_KP_GAIN     = 3'd0;
    localparam logic [2:0] CFG_KI_GAIN     = 3'd1;
    localparam logic [2:0] CFG_KD_GAIN     = 3'd2;
    localparam logic [2:0] CFG_CLIP_MIN    = 3'd3;
    localparam logic [2:0] CFG_CLIP_MAX    = 3'd4;
    localparam logic [2:0] CFG_CLIP_ENABLE = 3'd5;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_HIGH = 2'd1;
    localparam logic [1:0] CLAMP_LOW  = 2'd2;

    localparam logic signed [31:0] KP_RESET       = 32'sd65536;
    localparam logic signed [31:0] KI_RESET       = 32'sd65536;
    localparam logic signed [31:0] KD_RESET       = 32'sd65536;
    localparam logic signed [31:0] CLIP_MIN_RESET = -32'sd6553600;
    localparam logic signed [31:0] CLIP_MAX_RESET = 32'sd6553600;

    localparam logic [79:0] I_LIMIT   = 80'd6553600;
    localparam logic [63:0] D_CAP     = 64'h4000_0000_0000_0000;
    localparam int          DIV_STEPS = 32;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_SUMS,
        OP_MUL_AREA,
        OP_CAND,
        OP_MUL_P,
        OP_P,
        OP_MUL_T0,
        OP_T0,
        OP_MUL_T1,
        OP_T1,
        OP_MUL_R0,
        OP_R0,
        OP_MUL_R1,
        OP_R1,
        OP_MUL_R2,
        OP_R2,
        OP_MUL_D,
        OP_DIV_INIT,
        OP_DIV,
        OP_SUM,
        OP_OUT,
        OP_CLEAR
    } pta_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ERR,
        ST_SUMS,
        ST_MUL_AREA,
        ST_CAND,
        ST_MUL_P,
        ST_P,
        ST_MUL_T0,
        ST_T0,
        ST_MUL_T1,
        ST_T1,
        ST_MUL_R0,
        ST_R0,
        ST_MUL_R1,
        ST_R1,
        ST_MUL_R2,
        ST_R2,
        ST_MUL_D,
        ST_DIV_INIT,
        ST_DIV,
        ST_SUM,
        ST_OUT,
        ST_CLEAR
    } pta_state_t;

    typedef struct packed {
        pta_op_t op;
    } pta_cmd_t;

    typedef struct packed {
        logic dt_zero;
    } pta_status_t;

endpackage

### src/pid_trapezoid_antiwindup_unit.sv
// one item in flight at a time; a compute item with a zero time step skips the derivative
// multiply and divide
// the 64 by 32 bit derivative divide runs at two quotient bits per cycle
// the next item is accepted once the result sits in the output register
// reset: gains 1.0, limits -100.0 and 100.0, clipping off, stored errors zero
module pid_trapezoid_antiwindup_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  pta_pkg::pta_in_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output pta_pkg::pta_out_t out_item,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    pta_pkg::pta_cmd_t    cmd;
    pta_pkg::pta_status_t status;

    pta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (in_item.func),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pta_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule

### src/pta_datapath.sv
// datapath: config registers, shared multiplier, divider, controller state
module pta_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  pta_pkg::pta_in_t    in_item,
    input  pta_pkg::pta_cmd_t   cmd,
    output pta_pkg::pta_status_t status,
    output pta_pkg::pta_out_t   out_item
);

    logic signed [31:0] kp_reg, ki_reg, kd_reg, clip_min_reg, clip_max_reg;
    logic               clip_en_reg;
    logic signed [31:0] last_error_reg;
    logic signed [47:0] error_area_reg;

    pta_pkg::pta_in_t   in_reg;
    logic signed [31:0] e_reg;
    logic [31:0]        kp_mag_reg, ki_mag_reg, kd_mag_reg, sc_mag_reg;
    logic               p_neg_reg, i_neg_reg, d_neg_reg;
    logic               sum_neg_reg;
    logic [32:0]        sum_mag_reg, dif_mag_reg;
    logic signed [47:0] cand_reg;
    logic [47:0]        cand_mag_reg;
    logic [64:0]        prod_reg;
    logic signed [63:0] p_reg;
    logic [79:0]        t_reg;
    logic [111:0]       acc_reg;
    logic [63:0]        num_reg;
    logic [32:0]        rem_reg;
    logic signed [63:0] drive_reg;
    logic               over_reg;
    pta_pkg::pta_out_t  out_reg;

    logic [32:0]        mul_a;
    logic [31:0]        mul_b;
    logic signed [32:0] err_wide;
    logic signed [31:0] err_sat;
    logic signed [32:0] sum_wide, dif_wide;
    logic signed [49:0] cand_wide;
    logic signed [47:0] cand_sat;
    logic [96:0]        div_one, div_two;
    logic               over;
    logic signed [63:0] i_val, d_val;
    logic [63:0]        d_mag;
    logic signed [63:0] lim_hi, lim_lo, clip_res;
    logic signed [31:0] sat_res;
    logic               hit_hi, hit_lo;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [96:0] div_step(input logic [32:0] rem, input logic [63:0] num,
                                             input logic [31:0] dv);
        logic [32:0] trial;
        logic        take;
        trial = {rem[31:0], num[63]};
        take  = (trial >= {1'b0, dv});
        if (take)
        begin
            trial = trial - {1'b0, dv};
        end
        return {trial, num[62:0], take};
    endfunction

    assign status.dt_zero = (in_reg.delta_time == 32'd0);
    assign out_item       = out_reg;

    // error and its combinations with the stored error
    always_comb
    begin
        err_wide = {in_reg.set_point[31], in_reg.set_point}
                 - {in_reg.process_value[31], in_reg.process_value};
        if (err_wide[32] != err_wide[31])
        begin
            err_sat = err_wide[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            err_sat = err_wide[31:0];
        end
        sum_wide = {e_reg[31], e_reg} + {last_error_reg[31], last_error_reg};
        dif_wide = {e_reg[31], e_reg} - {last_error_reg[31], last_error_reg};
    end

    // candidate error area
    always_comb
    begin
        cand_wide = {{2{error_area_reg[47]}}, error_area_reg}
                  + (sum_neg_reg ? -50'sd0 - $signed({3'b0, prod_reg[63:17]})
                                 : $signed({3'b0, prod_reg[63:17]}));
        if (cand_wide > 50'sh0_7fff_ffff_ffff)
        begin
            cand_sat = 48'sh7fff_ffff_ffff;
        end
        else if (cand_wide < -50'sh0_8000_0000_0000)
        begin
            cand_sat = 48'sh8000_0000_0000;
        end
        else
        begin
            cand_sat = cand_wide[47:0];
        end
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = 33'd0;
        mul_b = 32'd0;
        unique case (cmd.op)
            pta_pkg::OP_MUL_AREA:
            begin
                mul_a = sum_mag_reg;
                mul_b = in_reg.delta_time;
            end
            pta_pkg::OP_MUL_P:
            begin
                mul_a = {1'b0, mag32(e_reg)};
                mul_b = kp_mag_reg;
            end
            pta_pkg::OP_MUL_T0:
            begin
                mul_a = {1'b0, cand_mag_reg[31:0]};
                mul_b = ki_mag_reg;
            end
            pta_pkg::OP_MUL_T1:
            begin
                mul_a = {17'd0, cand_mag_reg[47:32]};
                mul_b = ki_mag_reg;
            end
            pta_pkg::OP_MUL_R0:
            begin
                mul_a = {1'b0, t_reg[31:0]};
                mul_b = sc_mag_reg;
            end
            pta_pkg::OP_MUL_R1:
            begin
                mul_a = {1'b0, t_reg[63:32]};
                mul_b = sc_mag_reg;
            end
            pta_pkg::OP_MUL_R2:
            begin
                mul_a = {17'd0, t_reg[79:64]};
                mul_b = sc_mag_reg;
            end
            pta_pkg::OP_MUL_D:
            begin
                mul_a = dif_mag_reg;
                mul_b = kd_mag_reg;
            end
            default:
            begin
                mul_a = 33'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // two radix-2 divide steps per cycle
    always_comb
    begin
        div_one = div_step(rem_reg, num_reg, in_reg.delta_time);
        div_two = div_step(div_one[96:64], div_one[63:0], in_reg.delta_time);
    end

    // term combination
    always_comb
    begin
        over = (acc_reg[95:32] > pta_pkg::I_LIMIT);
        if (over)
        begin
            i_val = i_neg_reg ? -64'sd6553600 : 64'sd6553600;
        end
        else
        begin
            i_val = i_neg_reg ? -$signed(acc_reg[95:32]) : $signed(acc_reg[95:32]);
        end
        if (status.dt_zero)
        begin
            d_mag = 64'd0;
        end
        else
        begin
            d_mag = (num_reg > pta_pkg::D_CAP) ? pta_pkg::D_CAP : num_reg;
        end
        d_val = d_neg_reg ? -$signed(d_mag) : $signed(d_mag);
    end

    // output limits and saturation
    always_comb
    begin
        lim_hi = 64'(clip_max_reg);
        lim_lo = 64'(clip_min_reg);
        hit_hi = clip_en_reg && (drive_reg > lim_hi);
        hit_lo = clip_en_reg && !hit_hi && (drive_reg < lim_lo);
        priority if (hit_hi)
        begin
            clip_res = lim_hi;
        end
        else if (hit_lo)
        begin
            clip_res = lim_lo;
        end
        else
        begin
            clip_res = drive_reg;
        end
        if (clip_res > 64'sh7fff_ffff)
        begin
            sat_res = 32'sh7fff_ffff;
        end
        else if (clip_res < -64'sh8000_0000)
        begin
            sat_res = 32'sh8000_0000;
        end
        else
        begin
            sat_res = clip_res[31:0];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg       <= pta_pkg::KP_RESET;
            ki_reg       <= pta_pkg::KI_RESET;
            kd_reg       <= pta_pkg::KD_RESET;
            clip_min_reg <= pta_pkg::CLIP_MIN_RESET;
            clip_max_reg <= pta_pkg::CLIP_MAX_RESET;
            clip_en_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pta_pkg::CFG_KP_GAIN:     kp_reg       <= cfg_data;
                pta_pkg::CFG_KI_GAIN:     ki_reg       <= cfg_data;
                pta_pkg::CFG_KD_GAIN:     kd_reg       <= cfg_data;
                pta_pkg::CFG_CLIP_MIN:    clip_min_reg <= cfg_data;
                pta_pkg::CFG_CLIP_MAX:    clip_max_reg <= cfg_data;
                pta_pkg::CFG_CLIP_ENABLE: clip_en_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_error_reg <= '0;
            error_area_reg <= '0;
        end
        else if (cmd.op == pta_pkg::OP_CLEAR)
        begin
            last_error_reg <= '0;
            error_area_reg <= '0;
        end
        else if (cmd.op == pta_pkg::OP_OUT)
        begin
            last_error_reg <= e_reg;
            if (!over_reg)
            begin
                error_area_reg <= cand_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        prod_reg <= {32'd0, mul_a} * {33'd0, mul_b};
        unique case (cmd.op)
            pta_pkg::OP_LOAD:
            begin
                in_reg <= in_item;
            end
            pta_pkg::OP_ERR:
            begin
                e_reg      <= err_sat;
                kp_mag_reg <= mag32(kp_reg);
                ki_mag_reg <= mag32(ki_reg);
                kd_mag_reg <= mag32(kd_reg);
                sc_mag_reg <= mag32(in_reg.integral_scale);
            end
            pta_pkg::OP_SUMS:
            begin
                sum_neg_reg <= sum_wide[32];
                sum_mag_reg <= mag33(sum_wide);
                dif_mag_reg <= mag33(dif_wide);
                d_neg_reg   <= dif_wide[32] ^ kd_reg[31];
                p_neg_reg   <= e_reg[31] ^ kp_reg[31];
            end
            pta_pkg::OP_CAND:
            begin
                cand_reg <= cand_sat;
            end
            pta_pkg::OP_MUL_P:
            begin
                cand_mag_reg <= cand_reg[47] ? 48'(-cand_reg) : 48'(cand_reg);
                i_neg_reg    <= cand_reg[47] ^ ki_reg[31] ^ in_reg.integral_scale[31];
            end
            pta_pkg::OP_P:
            begin
                p_reg <= p_neg_reg ? -$signed({16'd0, prod_reg[63:16]})
                                   : $signed({16'd0, prod_reg[63:16]});
            end
            pta_pkg::OP_T0:
            begin
                t_reg <= {16'd0, prod_reg[63:0]};
            end
            pta_pkg::OP_T1:
            begin
                t_reg <= t_reg + {prod_reg[47:0], 32'd0};
            end
            pta_pkg::OP_R0:
            begin
                acc_reg <= {48'd0, prod_reg[63:0]};
            end
            pta_pkg::OP_R1:
            begin
                acc_reg <= acc_reg + {16'd0, prod_reg[63:0], 32'd0};
            end
            pta_pkg::OP_R2:
            begin
                acc_reg <= acc_reg + {prod_reg[47:0], 64'd0};
            end
            pta_pkg::OP_DIV_INIT:
            begin
                num_reg <= prod_reg[63:0];
                rem_reg <= 33'd0;
            end
            pta_pkg::OP_DIV:
            begin
                num_reg <= div_two[63:0];
                rem_reg <= div_two[96:64];
            end
            pta_pkg::OP_SUM:
            begin
                drive_reg <= p_reg + i_val + d_val;
                over_reg  <= over;
            end
            pta_pkg::OP_OUT:
            begin
                out_reg.drive            <= sat_res;
                out_reg.integral_clamped <= over_reg ? (i_neg_reg ? pta_pkg::CLAMP_LOW
                                                                  : pta_pkg::CLAMP_HIGH)
                                                     : pta_pkg::CLAMP_NONE;
                out_reg.output_clipped   <= (64'(sat_res) != drive_reg);
            end
            pta_pkg::OP_CLEAR:
            begin
                out_reg.drive            <= '0;
                out_reg.integral_clamped <= pta_pkg::CLAMP_NONE;
                out_reg.output_clipped   <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

### src/pta_ctrl.sv
// controller: sequences one item through the datapath and owns the handshakes
`include "pid_trapezoid_antiwindup_unit_defines.svh"

module pta_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    output logic                out_valid,
    input  logic                out_stall,
    input  pta_pkg::pta_status_t status,
    output pta_pkg::pta_cmd_t   cmd
);

    localparam int CntW = $clog2(pta_pkg::DIV_STEPS);

    pta_pkg::pta_state_t state_reg, state_next;
    logic [CntW-1:0]     div_cnt_reg, div_cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                slot_free;

    assign in_stall  = (state_reg != pta_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pta_pkg::ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = pta_pkg::OP_NONE;
        unique case (state_reg)
            pta_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = pta_pkg::OP_LOAD;
                    state_next = func ? pta_pkg::ST_CLEAR : pta_pkg::ST_ERR;
                end
            end
            pta_pkg::ST_ERR:
            begin
                cmd.op     = pta_pkg::OP_ERR;
                state_next = pta_pkg::ST_SUMS;
            end
            pta_pkg::ST_SUMS:
            begin
                cmd.op     = pta_pkg::OP_SUMS;
                state_next = pta_pkg::ST_MUL_AREA;
            end
            pta_pkg::ST_MUL_AREA:
            begin
                cmd.op     = pta_pkg::OP_MUL_AREA;
                state_next = pta_pkg::ST_CAND;
            end
            pta_pkg::ST_CAND:
            begin
                cmd.op     = pta_pkg::OP_CAND;
                state_next = pta_pkg::ST_MUL_P;
            end
            pta_pkg::ST_MUL_P:
            begin
                cmd.op     = pta_pkg::OP_MUL_P;
                state_next = pta_pkg::ST_P;
            end
            pta_pkg::ST_P:
            begin
                cmd.op     = pta_pkg::OP_P;
                state_next = pta_pkg::ST_MUL_T0;
            end
            pta_pkg::ST_MUL_T0:
            begin
                cmd.op     = pta_pkg::OP_MUL_T0;
                state_next = pta_pkg::ST_T0;
            end
            pta_pkg::ST_T0:
            begin
                cmd.op     = pta_pkg::OP_T0;
                state_next = pta_pkg::ST_MUL_T1;
            end
            pta_pkg::ST_MUL_T1:
            begin
                cmd.op     = pta_pkg::OP_MUL_T1;
                state_next = pta_pkg::ST_T1;
            end
            pta_pkg::ST_T1:
            begin
                cmd.op     = pta_pkg::OP_T1;
                state_next = pta_pkg::ST_MUL_R0;
            end
            pta_pkg::ST_MUL_R0:
            begin
                cmd.op     = pta_pkg::OP_MUL_R0;
                state_next = pta_pkg::ST_R0;
            end
            pta_pkg::ST_R0:
            begin
                cmd.op     = pta_pkg::OP_R0;
                state_next = pta_pkg::ST_MUL_R1;
            end
            pta_pkg::ST_MUL_R1:
            begin
                cmd.op     = pta_pkg::OP_MUL_R1;
                state_next = pta_pkg::ST_R1;
            end
            pta_pkg::ST_R1:
            begin
                cmd.op     = pta_pkg::OP_R1;
                state_next = pta_pkg::ST_MUL_R2;
            end
            pta_pkg::ST_MUL_R2:
            begin
                cmd.op     = pta_pkg::OP_MUL_R2;
                state_next = pta_pkg::ST_R2;
            end
            pta_pkg::ST_R2:
            begin
                cmd.op     = pta_pkg::OP_R2;
                state_next = status.dt_zero ? pta_pkg::ST_SUM : pta_pkg::ST_MUL_D;
            end
            pta_pkg::ST_MUL_D:
            begin
                cmd.op     = pta_pkg::OP_MUL_D;
                state_next = pta_pkg::ST_DIV_INIT;
            end
            pta_pkg::ST_DIV_INIT:
            begin
                cmd.op       = pta_pkg::OP_DIV_INIT;
                div_cnt_next = CntW'(pta_pkg::DIV_STEPS - 1);
                state_next   = pta_pkg::ST_DIV;
            end
            pta_pkg::ST_DIV:
            begin
                cmd.op       = pta_pkg::OP_DIV;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = pta_pkg::ST_SUM;
                end
            end
            pta_pkg::ST_SUM:
            begin
                cmd.op     = pta_pkg::OP_SUM;
                state_next = pta_pkg::ST_OUT;
            end
            pta_pkg::ST_OUT:
            begin
                if (slot_free)
                begin
                    cmd.op         = pta_pkg::OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = pta_pkg::ST_IDLE;
                end
            end
            pta_pkg::ST_CLEAR:
            begin
                if (slot_free)
                begin
                    cmd.op         = pta_pkg::OP_CLEAR;
                    out_valid_next = 1'b1;
                    state_next     = pta_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pta_pkg::ST_IDLE;
            end
        endcase
    end

    `PTA_ASSERT_NOW(a_no_overwrite,
        (cmd.op == pta_pkg::OP_OUT || cmd.op == pta_pkg::OP_CLEAR),
        !(out_valid_reg && out_stall), "result written over a waiting item")
    `PTA_ASSERT_NEXT(a_accept_leaves_idle, (in_valid && !in_stall),
        (state_reg != pta_pkg::ST_IDLE), "accepted item did not start")
    `PTA_ASSERT_NEXT(a_div_ends, (state_reg == pta_pkg::ST_DIV && div_cnt_reg == '0),
        (state_reg == pta_pkg::ST_SUM), "divider did not finish on count")

endmodule

### tb/sv/pid_trapezoid_antiwindup_unit_checker.sv
// checker for the pid trapezoid anti-windup unit: predicts each result and compares it
`timescale 1ns / 100ps

module pid_trapezoid_antiwindup_unit_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_stall,
    input  pta_pkg::pta_in_t  in_item,
    input  logic              out_valid,
    input  logic              out_stall,
    input  pta_pkg::pta_out_t out_item,
    input  logic              cfg_write,
    input  logic [2:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output int                fail_count,
    output int                pending
);

    logic signed [31:0] kp, ki, kd, lim_lo, lim_hi;
    logic               lim_on;
    logic signed [31:0] prev_err;
    logic signed [47:0] area_acc;
    pta_pkg::pta_out_t  drive_queue[$];

    assign pending = drive_queue.size();

    function automatic logic [127:0] mag(input logic signed [127:0] v);
        return v < 0 ? -v : v;
    endfunction

    task automatic predict_step(input pta_pkg::pta_in_t it);
        logic signed [127:0] err, sum, cand, p, i_term, d, drv, res, diff, dt;
        logic [127:0]        prod, q;
        logic                neg;
        pta_pkg::pta_out_t   r;
        r = '0;
        if (it.func)
        begin
            prev_err = '0;
            area_acc = '0;
            drive_queue.push_back(r);
            return;
        end
        dt = {96'd0, it.delta_time};
        err = 128'(it.set_point) - 128'(it.process_value);
        if (err > 128'sd2147483647) err = 128'sd2147483647;
        if (err < -128'sd2147483648) err = -128'sd2147483648;
        sum = err + 128'(prev_err);
        prod = (mag(sum) * dt) >> 17;
        cand = 128'(area_acc) + (sum < 0 ? -$signed(prod) : $signed(prod));
        if (cand > 128'sd140737488355327) cand = 128'sd140737488355327;
        if (cand < -128'sd140737488355328) cand = -128'sd140737488355328;
        prod = (mag(err) * mag(128'(kp))) >> 16;
        p = ((err < 0) != (kp < 0)) ? -$signed(prod) : $signed(prod);
        prod = (mag(cand) * mag(128'(ki)) * mag(128'(it.integral_scale))) >> 32;
        // the integral magnitude is kept to 64 bits
        prod = {64'd0, prod[63:0]};
        neg = ((cand < 0) != (ki < 0)) != (it.integral_scale < 0);
        if (prod > 128'd6553600)
        begin
            r.integral_clamped = neg ? pta_pkg::CLAMP_LOW : pta_pkg::CLAMP_HIGH;
            i_term = neg ? -128'sd6553600 : 128'sd6553600;
        end
        else
        begin
            i_term = neg ? -$signed(prod) : $signed(prod);
            area_acc = cand[47:0];
        end
        if (dt == 0)
            d = 0;
        else
        begin
            diff = err - 128'(prev_err);
            q = (mag(diff) * mag(128'(kd))) / dt;
            if (q > (128'd1 << 62)) q = 128'd1 << 62;
            d = ((diff < 0) != (kd < 0)) ? -$signed(q) : $signed(q);
        end
        prev_err = err[31:0];
        drv = p + i_term + d;
        res = drv;
        if (lim_on)
        begin
            if (res > 128'(lim_hi)) res = 128'(lim_hi);
            else if (res < 128'(lim_lo)) res = 128'(lim_lo);
        end
        if (res > 128'sd2147483647) res = 128'sd2147483647;
        if (res < -128'sd2147483648) res = -128'sd2147483648;
        r.output_clipped = (res != drv);
        r.drive = res[31:0];
        drive_queue.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pta_pkg::pta_out_t want;
        if (!rst_n)
        begin
            kp = pta_pkg::KP_RESET;
            ki = pta_pkg::KI_RESET;
            kd = pta_pkg::KD_RESET;
            lim_lo = pta_pkg::CLIP_MIN_RESET;
            lim_hi = pta_pkg::CLIP_MAX_RESET;
            lim_on = 1'b0;
            prev_err = '0;
            area_acc = '0;
            fail_count = 0;
            drive_queue.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    pta_pkg::CFG_KP_GAIN:     kp = cfg_data;
                    pta_pkg::CFG_KI_GAIN:     ki = cfg_data;
                    pta_pkg::CFG_KD_GAIN:     kd = cfg_data;
                    pta_pkg::CFG_CLIP_MIN:    lim_lo = cfg_data;
                    pta_pkg::CFG_CLIP_MAX:    lim_hi = cfg_data;
                    pta_pkg::CFG_CLIP_ENABLE: lim_on = cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (drive_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %h at %0t", out_item, $time);
                end
                else
                begin
                    want = drive_queue.pop_front();
                    if (want !== out_item)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch at %0t: expected drive %h clamp %0d clip %0d,",
                                      " got drive %h clamp %0d clip %0d"},
                                $time, want.drive, want.integral_clamped, want.output_clipped,
                                out_item.drive, out_item.integral_clamped,
                                out_item.output_clipped);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_step(in_item);
        end
    end
endmodule

### tb/sv/pid_trapezoid_antiwindup_unit_tb.sv
// top of the pid trapezoid anti-windup unit testbench: stimulus, configuration and verdict
`timescale 1ns / 100ps

module pid_trapezoid_antiwindup_unit_tb;

    localparam int IDLE_LIMIT = 20000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    pta_pkg::pta_in_t  in_item = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    pta_pkg::pta_out_t out_item;
    logic     cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    int       fail_count;
    int       pending;
    int       idle_cycles = 0;
    int       stall_mode = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    pid_trapezoid_antiwindup_unit DUT (.*);

    pid_trapezoid_antiwindup_unit_checker checker_i (.*);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("pid_trapezoid_antiwindup_unit_tb: errors");
            $finish;
        end
    end

    // receiver stall pattern, changes phase now and then
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return $urandom_range(0, 1) ? 32'(-$urandom_range(0, 6553600))
                                           : 32'($urandom_range(0, 6553600));
            4: return 32'(65536 + $urandom_range(0, 8191) - 4096);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_dt();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return $urandom;
            default: return $urandom_range(1, 1 << 17);
        endcase
    endfunction

    task automatic send(input pta_pkg::pta_in_t it);
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_step(input logic [31:0] pv, input logic [31:0] sp,
                             input logic [31:0] dt, input logic [31:0] sc);
        pta_pkg::pta_in_t it;
        it.func = 1'b0;
        it.process_value = pv;
        it.set_point = sp;
        it.delta_time = dt;
        it.integral_scale = sc;
        send(it);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic setup(input int mode);
        logic [31:0] a, b;
        a = pick_value();
        b = pick_value();
        case (mode)
            0:
            begin
                write_reg(pta_pkg::CFG_KP_GAIN, 32'h8000_0000);
                write_reg(pta_pkg::CFG_KI_GAIN, 32'h7fff_ffff);
                write_reg(pta_pkg::CFG_KD_GAIN, 32'h8000_0000);
                write_reg(pta_pkg::CFG_CLIP_MIN, 32'h8000_0000);
                write_reg(pta_pkg::CFG_CLIP_MAX, 32'h7fff_ffff);
                write_reg(pta_pkg::CFG_CLIP_ENABLE, 32'd1);
            end
            1:
            begin
                write_reg(pta_pkg::CFG_KP_GAIN, 32'd0);
                write_reg(pta_pkg::CFG_KI_GAIN, 32'd0);
                write_reg(pta_pkg::CFG_KD_GAIN, 32'h7fff_ffff);
                write_reg(pta_pkg::CFG_CLIP_MIN, 32'd6553600);
                write_reg(pta_pkg::CFG_CLIP_MAX, -32'sd6553600);
                write_reg(pta_pkg::CFG_CLIP_ENABLE, 32'hffff_fffe);
            end
            default:
            begin
                write_reg(pta_pkg::CFG_KP_GAIN, pick_value());
                write_reg(pta_pkg::CFG_KI_GAIN, pick_value());
                write_reg(pta_pkg::CFG_KD_GAIN, pick_value());
                write_reg(pta_pkg::CFG_CLIP_MIN, a);
                write_reg(pta_pkg::CFG_CLIP_MAX, b);
                write_reg(pta_pkg::CFG_CLIP_ENABLE, $urandom);
                write_reg(3'd6 + 3'($urandom_range(0, 1)), $urandom);
            end
        endcase
    endtask

    initial
    begin
        pta_pkg::pta_in_t it;
        int left;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zero step, clamps, clear
        send_step(32'h8000_0000, 32'h7fff_ffff, 32'd65536, 32'd65536);
        send_step(32'h7fff_ffff, 32'h8000_0000, 32'd65536, 32'd65536);
        send_step(32'd0, 32'd655360, 32'd0, 32'd65536);
        send_step(32'd0, 32'd655360, 32'hffff_ffff, 32'h7fff_ffff);
        send_step(32'd0, -32'sd655360, 32'hffff_ffff, 32'h8000_0000);
        send_step(32'd100, 32'd0, 32'd1, 32'd65536);
        it = '0;
        it.func = 1'b1;
        it.process_value = 32'hffff_ffff;
        it.set_point = 32'hffff_ffff;
        it.delta_time = 32'hffff_ffff;
        it.integral_scale = 32'hffff_ffff;
        send(it);
        send_step(32'd65536, 32'd131072, 32'd65536, 32'd0);
        send_step(32'd0, 32'd65536, 32'd32768, 32'd65536);
        drain();
        write_reg(pta_pkg::CFG_CLIP_ENABLE, 32'd1);
        send_step(32'd0, 32'h4000_0000, 32'd65536, 32'd65536);
        send_step(32'd0, 32'hc000_0000, 32'd65536, 32'd65536);
        send_step(32'd0, 32'd65536, 32'd65536, 32'd65536);
        drain();
        for (int m = 0; m < 2; m++)
        begin
            setup(m);
            send_step(32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff);
            send_step(32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'h8000_0000);
            send_step(32'd0, 32'd1, 32'd0, 32'd65536);
            drain();
        end

        left = 950;
        while (left > 0)
        begin
            setup(2 + $urandom_range(0, 3));
            for (int k = 0; k < 120 && left > 0; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 60)) @(posedge clk);
                it.func = ($urandom_range(0, 24) == 0);
                it.process_value = pick_value();
                it.set_point = ($urandom_range(0, 2) == 0) ? pick_value()
                    : it.process_value + 32'($signed($urandom_range(0, 1310720)) - 655360);
                it.delta_time = pick_dt();
                it.integral_scale = ($urandom_range(0, 1) == 0) ? 32'd65536 : pick_value();
                send(it);
                left--;
            end
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("pid_trapezoid_antiwindup_unit_tb: clean");
        else
            $display("pid_trapezoid_antiwindup_unit_tb: errors");
        $finish;
    end
endmodule

### files.f
+incdir+src
src/pta_pkg.sv
src/pta_datapath.sv
src/pta_ctrl.sv
src/pid_trapezoid_antiwindup_unit.sv
tb/sv/pid_trapezoid_antiwindup_unit_checker.sv
tb/sv/pid_trapezoid_antiwindup_unit_tb.sv
